>>> hw/rtl/tbt_pkg.sv
package tbt_pkg;

  localparam int POS_W       = 32;
  localparam int UV_W        = 16;
  localparam int UV_FRAC_BITS = 12;
  localparam int DP_W        = POS_W + 1;
  localparam int DUV_W       = UV_W + 1;
  localparam int PROD_W      = DP_W + DUV_W;
  localparam int NUM_W       = PROD_W + 1;
  localparam int DEN_W       = 2 * DUV_W;
  localparam int DVD_W       = NUM_W + UV_FRAC_BITS;
  localparam int CNT_W       = $clog2(DVD_W);
  localparam int VERTS       = 3;
  localparam int COMPS       = 6;
  localparam int QDEPTH      = 2;

  typedef logic signed [DP_W-1:0]  dp_t;
  typedef logic signed [DUV_W-1:0] duv_t;

  // one triangle, edges and uv deltas ready for the back end
  typedef struct packed {
    dp_t [2:0] dp1;
    dp_t [2:0] dp2;
    duv_t      du1;
    duv_t      dv1;
    duv_t      du2;
    duv_t      dv2;
  } tri_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> hw/rtl/triangle_tangent_bitangent.sv
// Tangent/bitangent per triangle from a triangle-list vertex stream, one
// vertex (Q16.16 position, Q4.12 uv) per input word. Every third vertex
// closes a triangle and yields three identical output words, the last one
// flagged last_of_triangle; a zero uv determinant gives zero vectors with
// degenerate set. Components are rounded half away from zero and
// saturated to 32 bits. The front end takes a vertex per cycle, except
// that a closing vertex waits while the two-deep triangle queue is full,
// so it keeps accepting while the back end works. Per triangle the back
// end does a pop, the determinant multiply and subtract, then for each of
// the six components a multiply, a subtract, a restoring divide and a
// round step on one shared divider, then three output beats; a degenerate
// triangle skips the components, and a triangle ends before the next pop.
module triangle_tangent_bitangent (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] tex_u,
  input  logic signed [15:0] tex_v,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] tangent_x,
  output logic signed [31:0] tangent_y,
  output logic signed [31:0] tangent_z,
  output logic signed [31:0] bitangent_x,
  output logic signed [31:0] bitangent_y,
  output logic signed [31:0] bitangent_z,
  output logic               degenerate,
  output logic               last_of_triangle
);
  import tbt_pkg::*;

  q_stat_t q_stat;
  tri_t    push_data, pop_data;
  logic    push, pop;

  // vertex capture and edge/delta forming
  tbt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .tex_u     (tex_u),
    .tex_v     (tex_v),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // decouples vertex intake from the divide sequencer
  tbt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // determinant, numerators, division and the three output words
  tbt_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_stat           (q_stat),
    .pop_data         (pop_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .tangent_x        (tangent_x),
    .tangent_y        (tangent_y),
    .tangent_z        (tangent_z),
    .bitangent_x      (bitangent_x),
    .bitangent_y      (bitangent_y),
    .bitangent_z      (bitangent_z),
    .degenerate       (degenerate),
    .last_of_triangle (last_of_triangle)
  );

endmodule

>>> hw/rtl/tbt_front.sv
module tbt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            pos_x,
  input  logic signed [31:0]            pos_y,
  input  logic signed [31:0]            pos_z,
  input  logic signed [15:0]            tex_u,
  input  logic signed [15:0]            tex_v,
  input  tbt_pkg::q_stat_t              q_stat,
  output logic                          push,
  output tbt_pkg::tri_t                 push_data
);
  import tbt_pkg::*;

  logic [1:0] phase;
  logic signed [POS_W-1:0] p0 [3];
  logic signed [POS_W-1:0] p1 [3];
  logic signed [UV_W-1:0]  u0, v0, u1, v1;
  logic accept;

  assign in_ready = (phase != 2'd2) || !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (phase == 2'd2);

  always_comb begin
    logic signed [POS_W-1:0] cur [3];
    cur[0] = pos_x;
    cur[1] = pos_y;
    cur[2] = pos_z;
    for (int i = 0; i < 3; i++) begin
      push_data.dp1[i] = DP_W'(p1[i]) - DP_W'(p0[i]);
      push_data.dp2[i] = DP_W'(cur[i]) - DP_W'(p0[i]);
    end
    push_data.du1 = DUV_W'(u1) - DUV_W'(u0);
    push_data.dv1 = DUV_W'(v1) - DUV_W'(v0);
    push_data.du2 = DUV_W'(tex_u) - DUV_W'(u0);
    push_data.dv2 = DUV_W'(tex_v) - DUV_W'(v0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
    end else if (accept) begin
      case (phase)
        2'd1: begin
          p1[0] <= pos_x;
          p1[1] <= pos_y;
          p1[2] <= pos_z;
          u1    <= tex_u;
          v1    <= tex_v;
          phase <= 2'd2;
        end
        2'd2: begin
          phase <= 2'd0;
        end
        default: begin
          p0[0] <= pos_x;
          p0[1] <= pos_y;
          p0[2] <= pos_z;
          u0    <= tex_u;
          v0    <= tex_v;
          phase <= 2'd1;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/tbt_queue.sv
module tbt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tbt_pkg::tri_t    push_data,
  input  logic             pop,
  output tbt_pkg::tri_t    pop_data,
  output tbt_pkg::q_stat_t q_stat
);
  import tbt_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  tri_t              slots [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [PTR_W:0]    count;

  assign pop_data     = slots[rd_ptr];
  assign q_stat.full  = (count == (PTR_W+1)'(QDEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> hw/rtl/tbt_back.sv
module tbt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  tbt_pkg::q_stat_t     q_stat,
  input  tbt_pkg::tri_t        pop_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   tangent_x,
  output logic signed [31:0]   tangent_y,
  output logic signed [31:0]   tangent_z,
  output logic signed [31:0]   bitangent_x,
  output logic signed [31:0]   bitangent_y,
  output logic signed [31:0]   bitangent_z,
  output logic                 degenerate,
  output logic                 last_of_triangle
);
  import tbt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DMUL, S_DSUB, S_CMUL, S_CSUB, S_DIV, S_ROUND, S_OUT
  } state_t;

  state_t                   state;
  tri_t                     job;
  logic [2:0]               comp;
  logic signed [PROD_W-1:0] prod_a, prod_b;
  logic                     det_neg, neg, degen;
  logic [DEN_W-1:0]         den, rem;
  logic [DVD_W-1:0]         dvd, quo;
  logic [CNT_W-1:0]         cnt;
  logic [1:0]               beat;
  logic [POS_W-1:0]         res [COMPS];

  logic signed [DP_W-1:0]   ma1, mb1;
  logic signed [DUV_W-1:0]  ma2, mb2;
  logic [1:0]               idx;
  logic signed [NUM_W-1:0]  diff;
  logic [NUM_W-1:0]         mag;
  logic [DEN_W:0]           shifted;
  logic [DVD_W-1:0]         qr;
  logic [POS_W-1:0]         sat;

  assign pop = (state == S_IDLE) && !q_stat.empty;

  // operand select for the shared multiplier pair
  always_comb begin
    idx = (comp < 3'd3) ? comp[1:0] : 2'(comp - 3'd3);
    if (state == S_DMUL) begin
      ma1 = DP_W'($signed(job.du1));
      ma2 = $signed(job.dv2);
      mb1 = DP_W'($signed(job.dv1));
      mb2 = $signed(job.du2);
    end else if (comp < 3'd3) begin
      ma1 = $signed(job.dp1[idx]);
      ma2 = $signed(job.dv2);
      mb1 = $signed(job.dp2[idx]);
      mb2 = $signed(job.dv1);
    end else begin
      ma1 = $signed(job.dp2[idx]);
      ma2 = $signed(job.du1);
      mb1 = $signed(job.dp1[idx]);
      mb2 = $signed(job.du2);
    end
  end

  always_comb begin
    diff    = NUM_W'(prod_a) - NUM_W'(prod_b);
    mag     = diff[NUM_W-1] ? NUM_W'(-diff) : NUM_W'(diff);
    shifted = {rem, dvd[DVD_W-1]};
    // round half away from zero on the magnitude, then saturate
    qr = quo + DVD_W'({rem, 1'b0} >= {1'b0, den});
    if (neg) begin
      if (qr > DVD_W'(33'h0_8000_0000)) sat = 32'h8000_0000;
      else                              sat = POS_W'(-qr);
    end else begin
      if (qr > DVD_W'(32'h7FFF_FFFF))   sat = 32'h7FFF_FFFF;
      else                              sat = POS_W'(qr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      beat      <= 2'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            job   <= pop_data;
            comp  <= 3'd0;
            state <= S_DMUL;
          end
        end
        S_DMUL: begin
          prod_a <= PROD_W'(ma1 * ma2);
          prod_b <= PROD_W'(mb1 * mb2);
          degen  <= 1'b0;
          state  <= S_DSUB;
        end
        S_DSUB: begin
          det_neg <= diff[NUM_W-1];
          den     <= DEN_W'(mag);
          if (diff == '0) begin
            for (int i = 0; i < COMPS; i++) res[i] <= '0;
            degen     <= 1'b1;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            state <= S_CMUL;
          end
        end
        S_CMUL: begin
          prod_a <= PROD_W'(ma1 * ma2);
          prod_b <= PROD_W'(mb1 * mb2);
          state  <= S_CSUB;
        end
        S_CSUB: begin
          neg   <= diff[NUM_W-1] ^ det_neg;
          dvd   <= {mag, UV_FRAC_BITS'(0)};
          quo   <= '0;
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (shifted >= {1'b0, den}) begin
            rem <= DEN_W'(shifted - {1'b0, den});
            quo <= {quo[DVD_W-2:0], 1'b1};
          end else begin
            rem <= shifted[DEN_W-1:0];
            quo <= {quo[DVD_W-2:0], 1'b0};
          end
          dvd <= {dvd[DVD_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DVD_W - 1)) state <= S_ROUND;
        end
        S_ROUND: begin
          res[comp] <= sat;
          if (comp == 3'(COMPS - 1)) begin
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            comp  <= comp + 3'd1;
            state <= S_CMUL;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (beat == 2'(VERTS - 1)) begin
              beat      <= 2'd0;
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              beat <= beat + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign tangent_x        = res[0];
  assign tangent_y        = res[1];
  assign tangent_z        = res[2];
  assign bitangent_x      = res[3];
  assign bitangent_y      = res[4];
  assign bitangent_z      = res[5];
  assign degenerate       = degen;
  assign last_of_triangle = (beat == 2'(VERTS - 1));

endmodule

>>> sim/triangle_tangent_bitangent_tb.sv
`timescale 1ns / 1ps

module triangle_tangent_bitangent_tb;
  import tbt_pkg::*;

  // one output word of the block
  typedef struct {
    logic signed [31:0] tan_x, tan_y, tan_z;
    logic signed [31:0] bit_x, bit_y, bit_z;
    logic               degen;
    logic               last;
  } tb_word_t;

  // one vertex of the stream
  typedef struct {
    logic signed [31:0] x, y, z;
    logic signed [15:0] u, v;
  } vertex_t;

  // one row of the directed table; chk_zero means the expected words are
  // the degenerate ones, read straight off the spec
  typedef struct {
    vertex_t vtx;
    bit      chk_zero;
  } stim_row_t;

  localparam int N_DIRECTED = 21;
  localparam int N_RANDOM   = 150;
  localparam logic signed [31:0] P_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] P_MIN = 32'sh80000000;
  localparam logic signed [15:0] T_MAX = 16'sh7fff;
  localparam logic signed [15:0] T_MIN = 16'sh8000;
  localparam logic signed [15:0] T_ONE = 16'sh1000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [15:0] tex_u = '0, tex_v = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] tangent_x, tangent_y, tangent_z;
  logic signed [31:0] bitangent_x, bitangent_y, bitangent_z;
  logic               degenerate, last_of_triangle;

  triangle_tangent_bitangent u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
    .out_valid(out_valid), .out_ready(out_ready),
    .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
    .bitangent_x(bitangent_x), .bitangent_y(bitangent_y),
    .bitangent_z(bitangent_z),
    .degenerate(degenerate), .last_of_triangle(last_of_triangle)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state: the two held vertices and the phase in the triangle
  vertex_t    held_vtx [2];
  int         tri_phase;
  tb_word_t   pending_words[$];
  int         err_cnt;
  bit         hold_off_req;
  bit         stim_done;
  stim_row_t  dir_rows [N_DIRECTED];

  // round(num * 2^12 / det) half away from zero, saturated to 32 bits
  function automatic logic signed [31:0] shade_quot(logic signed [127:0] num,
                                                    logic signed [127:0] det);
    logic                neg;
    logic [127:0]        mn, md, q, r;
    neg = (num < 0) != (det < 0);
    mn  = (num < 0) ? -num : num;
    md  = (det < 0) ? -det : det;
    mn  = mn << UV_FRAC_BITS;
    q   = mn / md;
    r   = mn % md;
    if (2 * r >= md) q = q + 1;
    if (neg) begin
      if (q > 128'h80000000) return P_MIN;
      return -q[31:0];
    end
    if (q > 128'h7fffffff) return P_MAX;
    return q[31:0];
  endfunction

  // advance the triangle assembler by one vertex, queuing any output words
  task automatic predict_vertex(input vertex_t vt);
    logic signed [127:0] p0 [3], dp1 [3], dp2 [3], c2 [3];
    logic signed [127:0] du1, dv1, du2, dv2, det;
    tb_word_t            w;
    if (tri_phase < 2) begin
      held_vtx[tri_phase] = vt;
      tri_phase++;
      return;
    end
    tri_phase = 0;
    p0[0] = held_vtx[0].x; p0[1] = held_vtx[0].y; p0[2] = held_vtx[0].z;
    dp1[0] = held_vtx[1].x - p0[0];
    dp1[1] = held_vtx[1].y - p0[1];
    dp1[2] = held_vtx[1].z - p0[2];
    c2[0] = vt.x; c2[1] = vt.y; c2[2] = vt.z;
    for (int i = 0; i < 3; i++) dp2[i] = c2[i] - p0[i];
    du1 = held_vtx[1].u - held_vtx[0].u;
    dv1 = held_vtx[1].v - held_vtx[0].v;
    du2 = vt.u - held_vtx[0].u;
    dv2 = vt.v - held_vtx[0].v;
    det = du1 * dv2 - dv1 * du2;
    w = '{default: '0};
    if (det == 0) begin
      w.degen = 1'b1;
    end else begin
      w.tan_x = shade_quot(dp1[0] * dv2 - dp2[0] * dv1, det);
      w.tan_y = shade_quot(dp1[1] * dv2 - dp2[1] * dv1, det);
      w.tan_z = shade_quot(dp1[2] * dv2 - dp2[2] * dv1, det);
      w.bit_x = shade_quot(dp2[0] * du1 - dp1[0] * du2, det);
      w.bit_y = shade_quot(dp2[1] * du1 - dp1[1] * du2, det);
      w.bit_z = shade_quot(dp2[2] * du1 - dp1[2] * du2, det);
    end
    for (int k = 0; k < VERTS; k++) begin
      w.last = (k == VERTS - 1);
      pending_words.push_back(w);
    end
  endtask

  function automatic vertex_t mk_vtx(logic signed [31:0] x, y, z,
                                     logic signed [15:0] u, v);
    vertex_t vt;
    vt.x = x; vt.y = y; vt.z = z; vt.u = u; vt.v = v;
    return vt;
  endfunction

  // random position: mostly modest values, sometimes full range or extremes
  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? P_MAX : P_MIN;
      default: return $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_tex();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? T_MAX : T_MIN;
      default: return $signed(16'($urandom_range(0, 16'h1fff))) - 16'sh1000;
    endcase
  endfunction

  // valid drops only across a gap, so back to back words keep it high
  task automatic send_vertex(input vertex_t vt);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= vt.x; pos_y <= vt.y; pos_z <= vt.z;
    tex_u <= vt.u; tex_v <= vt.v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_vertex(vt);
  endtask

  // directed table: every triangle against the predictor, degenerate ones
  // also checked at a glance
  initial begin
    // all zero: zero uv area
    dir_rows[0] = '{mk_vtx(0, 0, 0, 0, 0), 1'b0};
    dir_rows[1] = '{mk_vtx(0, 0, 0, 0, 0), 1'b0};
    dir_rows[2] = '{mk_vtx(0, 0, 0, 0, 0), 1'b1};
    // unit right triangle in uv
    dir_rows[3] = '{mk_vtx(0, 0, 0, 0, 0), 1'b0};
    dir_rows[4] = '{mk_vtx(32'sh10000, 0, 0, T_ONE, 0), 1'b0};
    dir_rows[5] = '{mk_vtx(0, 32'sh10000, 0, 0, T_ONE), 1'b0};
    // position extremes, tiny uv area: saturates both ways
    dir_rows[6] = '{mk_vtx(P_MIN, P_MAX, P_MIN, 0, 0), 1'b0};
    dir_rows[7] = '{mk_vtx(P_MAX, P_MIN, P_MAX, 16'sd1, 0), 1'b0};
    dir_rows[8] = '{mk_vtx(P_MIN, P_MIN, P_MAX, 0, 16'sd1), 1'b0};
    // uv extremes, collinear: degenerate
    dir_rows[9]  = '{mk_vtx(P_MAX, 5, -7, T_MIN, T_MIN), 1'b0};
    dir_rows[10] = '{mk_vtx(P_MIN, -5, 7, T_MAX, T_MAX), 1'b0};
    dir_rows[11] = '{mk_vtx(3, 9, 1, T_MIN, T_MIN), 1'b1};
    // uv extremes, widest area
    dir_rows[12] = '{mk_vtx(-1, -1, -1, T_MIN, T_MIN), 1'b0};
    dir_rows[13] = '{mk_vtx(P_MAX, 0, P_MIN, T_MAX, T_MIN), 1'b0};
    dir_rows[14] = '{mk_vtx(0, P_MAX, -1, T_MIN, T_MAX), 1'b0};
    // rounding and negative area
    dir_rows[15] = '{mk_vtx(0, 0, 0, 0, 0), 1'b0};
    dir_rows[16] = '{mk_vtx(1, 3, -1, 0, 16'sd3), 1'b0};
    dir_rows[17] = '{mk_vtx(-3, 1, 5, 16'sd2, 0), 1'b0};
    // all ones bit patterns, degenerate: identical uv
    dir_rows[18] = '{mk_vtx(-1, -1, -1, -1, -1), 1'b0};
    dir_rows[19] = '{mk_vtx(P_MAX, P_MAX, P_MAX, -1, -1), 1'b0};
    dir_rows[20] = '{mk_vtx(P_MIN, P_MIN, P_MIN, -1, -1), 1'b1};
  end

  // stimulus
  initial begin
    vertex_t vt;
    int      n_deg;
    tri_phase    = 0;
    err_cnt      = 0;
    hold_off_req = 1'b0;
    stim_done    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      n_deg = pending_words.size();
      send_vertex(dir_rows[i].vtx);
      // table check: a degenerate triangle expects the flag set, tan_x and bit_z zero
      if (dir_rows[i].chk_zero)
        for (int k = n_deg; k < pending_words.size(); k++)
          if (!pending_words[k].degen || pending_words[k].tan_x != 0 ||
              pending_words[k].bit_z != 0) begin
            $display("%0t: table row %0d exp degenerate 1 got %0b", $time, i,
                     pending_words[k].degen);
            err_cnt++;
          end
    end

    // sender pause: drain everything the directed part produced
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);

    // receiver holds off while we keep feeding, so the queue backs up
    hold_off_req = 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 30) hold_off_req = 1'b0;
      if ($urandom_range(0, 9) == 0)
        vt = mk_vtx($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom));
      else
        vt = mk_vtx(rand_pos(), rand_pos(), rand_pos(), rand_tex(), rand_tex());
      // occasionally force a degenerate close of the triangle
      if (tri_phase == 2 && $urandom_range(0, 7) == 0) begin
        vt.u = held_vtx[0].u; vt.v = held_vtx[0].v;
      end
      send_vertex(vt);
    end
    // close a dangling triangle so every vertex is accounted for
    while (tri_phase != 0)
      send_vertex(mk_vtx(rand_pos(), rand_pos(), rand_pos(), rand_tex(), rand_tex()));
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int stall_cnt;
    int gap;
    bit held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 5);
      if (hold_off_req && !held) begin
        held      = 1'b1;
        stall_cnt = 0;
        out_ready <= 1'b0;
        while (stall_cnt < 2000) begin
          @(posedge clk);
          stall_cnt++;
        end
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // checker: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    tb_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected output word", $time);
        err_cnt++;
      end else begin
        w = pending_words.pop_front();
        if (tangent_x !== w.tan_x) begin
          $display("%0t: tangent_x exp %0d got %0d", $time, w.tan_x, tangent_x);
          err_cnt++;
        end
        if (tangent_y !== w.tan_y) begin
          $display("%0t: tangent_y exp %0d got %0d", $time, w.tan_y, tangent_y);
          err_cnt++;
        end
        if (tangent_z !== w.tan_z) begin
          $display("%0t: tangent_z exp %0d got %0d", $time, w.tan_z, tangent_z);
          err_cnt++;
        end
        if (bitangent_x !== w.bit_x) begin
          $display("%0t: bitangent_x exp %0d got %0d", $time, w.bit_x, bitangent_x);
          err_cnt++;
        end
        if (bitangent_y !== w.bit_y) begin
          $display("%0t: bitangent_y exp %0d got %0d", $time, w.bit_y, bitangent_y);
          err_cnt++;
        end
        if (bitangent_z !== w.bit_z) begin
          $display("%0t: bitangent_z exp %0d got %0d", $time, w.bit_z, bitangent_z);
          err_cnt++;
        end
        if (degenerate !== w.degen) begin
          $display("%0t: degenerate exp %0b got %0b", $time, w.degen, degenerate);
          err_cnt++;
        end
        if (last_of_triangle !== w.last) begin
          $display("%0t: last_of_triangle exp %0b got %0b", $time, w.last,
                   last_of_triangle);
          err_cnt++;
        end
      end
    end
  end

  // end of run: drain, then let the block settle and report
  initial begin
    wait (stim_done);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (err_cnt == 0 && pending_words.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // watchdog: ~60 triangles plus stalls, taken many times over
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
